### design/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies; used by first_fit_heap_allocator_top.
`default_nettype none

package ffha_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int SPLIT_MIN        = 32;
    localparam int ALIGN_MASK       = 7;

    localparam logic [16:0] HEAP_LIMIT_RST = 17'd65536;

    typedef enum logic [0:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_ALLOC   = 3'd0,
        ST_FREED   = 3'd1,
        ST_ZERO    = 3'd2,
        ST_NOSPACE = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FNEXT,
        S_SHUP,
        S_SHDN,
        S_RESP
    } t_state;

    // One table entry: free mark and payload size.
    typedef struct packed {
        logic        free;
        logic [15:0] size;
    } t_entry;

endpackage

`default_nettype wire

### design/first_fit_heap_allocator_top.sv
// First-fit heap allocator with splitting and coalescing, top level.
// Depends on ffha_pkg.
`default_nettype none

// The block keeps an address-ordered table of heap blocks (payload size and
// free mark) in one synchronous RAM of MAX_BLOCKS entries and serves one
// request at a time. An allocate rounds its size up to a multiple of 8 bytes
// and walks the table from entry 0 for the first free block that fits, else
// appends a block at the heap top if the table and heap limit allow; a free
// walks the table until the running header offset matches the address. The
// walk reads one entry per cycle through the RAM's single read port. A split
// shifts the entries above the hit up by one and a merge shifts them down by
// one or two, again one entry per cycle. The shift only covers the entries
// the walk did not reach, so scan plus shift stays within one pass over the
// table. Zero-size allocates and null frees skip the walk and go straight to
// the response. Input stall is high whenever a request is in work; the result
// sits in an output register so the next request can be taken while it waits.
// The heap limit register may be written at any time the block is idle and
// is always ready.

module first_fit_heap_allocator_top #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [15:0] i_request_size,
    input  wire logic [15:0] i_free_address,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_payload_address,
    output logic [2:0]       o_status,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_heap_limit
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int RW = CW + 1;

    localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);
    localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);
    localparam logic [17:0] HDR18 = 18'(HEADER_BYTES);
    localparam logic [18:0] HDR19 = 19'(HEADER_BYTES);
    localparam logic [17:0] SPL18 = 18'(ffha_pkg::SPLIT_MIN);
    localparam logic [16:0] ALN17 = 17'(ffha_pkg::ALIGN_MASK);
    localparam logic [16:0] HEAP17 = 17'(HEAP_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    // block table
    ffha_pkg::t_entry r_mem [MAX_BLOCKS];
    ffha_pkg::t_entry r_rdata;
    logic             w_we;
    logic [IW-1:0]    w_wa;
    logic [IW-1:0]    w_ra;
    ffha_pkg::t_entry w_wd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
    end

    ffha_pkg::t_state  r_state, n_state;
    logic              r_func, n_func;
    logic [16:0]       r_sz, n_sz;
    logic [15:0]       r_where, n_where;
    logic [RW-1:0]     r_ra, n_ra;       // scan pointer / shift source
    logic              r_pend, n_pend;   // read data valid this cycle
    logic [IW-1:0]     r_cur, n_cur;     // entry of the arriving data
    logic [16:0]       r_pos, n_pos;     // header offset of r_cur
    ffha_pkg::t_entry  r_prev, n_prev;
    ffha_pkg::t_entry  r_hit, n_hit;
    logic [IW-1:0]     r_i, n_i;
    logic [15:0]       r_rem, n_rem;
    logic [1:0]        r_d, n_d;
    logic [CW-1:0]     r_count, n_count;
    logic [16:0]       r_top, n_top;
    logic [16:0]       r_limit, n_limit;
    logic [15:0]       r_res_addr, n_res_addr;
    logic [2:0]        r_res_st, n_res_st;
    logic              r_ovalid, n_ovalid;
    logic [15:0]       r_oaddr, n_oaddr;
    logic [2:0]        r_ost, n_ost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffha_pkg::S_IDLE;
            r_pend   <= 1'b0;
            r_count  <= '0;
            r_top    <= '0;
            r_limit  <= ffha_pkg::HEAP_LIMIT_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_count  <= n_count;
            r_top    <= n_top;
            r_limit  <= n_limit;
            r_ovalid <= n_ovalid;
        end
        r_func     <= n_func;
        r_sz       <= n_sz;
        r_where    <= n_where;
        r_ra       <= n_ra;
        r_cur      <= n_cur;
        r_pos      <= n_pos;
        r_prev     <= n_prev;
        r_hit      <= n_hit;
        r_i        <= n_i;
        r_rem      <= n_rem;
        r_d        <= n_d;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        r_oaddr    <= n_oaddr;
        r_ost      <= n_ost;
    end

    logic        w_out_acc;
    logic        w_hit;
    logic        w_split;
    logic [16:0] w_limit;
    logic        w_nf;
    logic        w_pf;

    assign o_stall           = (r_state != ffha_pkg::S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_payload_address = r_oaddr;
    assign o_status          = r_ost;
    assign o_cfg_ready       = 1'b1;
    assign w_out_acc         = r_ovalid & ~i_stall;
    assign w_limit           = (r_limit < HEAP17) ? r_limit : HEAP17;

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_sz       = r_sz;
        n_where    = r_where;
        n_ra       = r_ra;
        n_pend     = r_pend;
        n_cur      = r_cur;
        n_pos      = r_pos;
        n_prev     = r_prev;
        n_hit      = r_hit;
        n_i        = r_i;
        n_rem      = r_rem;
        n_d        = r_d;
        n_count    = r_count;
        n_top      = r_top;
        n_limit    = (i_cfg_valid) ? i_cfg_heap_limit : r_limit;
        n_res_addr = r_res_addr;
        n_res_st   = r_res_st;
        n_ovalid   = w_out_acc ? 1'b0 : r_ovalid;
        n_oaddr    = r_oaddr;
        n_ost      = r_ost;
        w_we       = 1'b0;
        w_wa       = '0;
        w_wd       = '0;
        w_ra       = '0;
        w_hit      = 1'b0;
        w_split    = 1'b0;
        w_nf       = 1'b0;
        w_pf       = 1'b0;

        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_func     = i_func;
                    n_sz       = ({1'b0, i_request_size} + ALN17) & ~ALN17;
                    n_where    = i_free_address;
                    n_ra       = '0;
                    n_pend     = 1'b0;
                    n_pos      = '0;
                    n_res_addr = '0;
                    n_state    = ffha_pkg::S_SCAN;
                    if (i_func == ffha_pkg::FN_FREE) begin
                        if (i_free_address == 16'd0) begin
                            n_res_st = ffha_pkg::ST_IGNORED;
                            n_state  = ffha_pkg::S_RESP;
                        end
                    end else if (i_request_size == 16'd0) begin
                        n_res_st = ffha_pkg::ST_ZERO;
                        n_state  = ffha_pkg::S_RESP;
                    end
                end
            end

            ffha_pkg::S_SCAN: begin
                if (r_func == ffha_pkg::FN_ALLOC) begin
                    w_hit = r_pend && r_rdata.free && ({1'b0, r_rdata.size} >= r_sz);
                end else begin
                    w_hit = r_pend && (({1'b0, r_pos} + HDR18) == {2'b0, r_where});
                end
                if (w_hit) begin
                    n_hit = r_rdata;
                    n_i   = r_cur;
                    if (r_func == ffha_pkg::FN_ALLOC) begin
                        w_split = ({2'b0, r_rdata.size} >= ({1'b0, r_sz} + HDR18 + SPL18))
                                  && (r_count < MAXC);
                        n_res_addr = 16'(r_pos + HDR17);
                        n_res_st   = ffha_pkg::ST_ALLOC;
                        w_we       = 1'b1;
                        w_wa       = r_cur;
                        w_wd.free  = 1'b0;
                        w_wd.size  = w_split ? r_sz[15:0] : r_rdata.size;
                        if (w_split) begin
                            n_rem   = r_rdata.size - r_sz[15:0] - HDR16;
                            n_ra    = RW'(r_count);
                            n_pend  = 1'b0;
                            n_state = ffha_pkg::S_SHUP;
                        end else begin
                            n_state = ffha_pkg::S_RESP;
                        end
                    end else begin
                        // fetch the right neighbor for the merge
                        w_ra     = r_cur + 1'b1;
                        n_res_st = ffha_pkg::ST_FREED;
                        n_state  = ffha_pkg::S_FNEXT;
                    end
                end else begin
                    if (r_pend) begin
                        n_pos  = r_pos + HDR17 + {1'b0, r_rdata.size};
                        n_prev = r_rdata;
                    end
                    if (r_ra < RW'(r_count)) begin
                        w_ra   = r_ra[IW-1:0];
                        n_cur  = r_ra[IW-1:0];
                        n_ra   = r_ra + 1'b1;
                        n_pend = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            // walked off the end of the table
                            n_state = ffha_pkg::S_RESP;
                            if (r_func == ffha_pkg::FN_FREE) begin
                                n_res_st = ffha_pkg::ST_IGNORED;
                            end else if ((r_count >= MAXC) ||
                                ({2'b0, r_top} + HDR19 + {2'b0, r_sz} >
                                 {2'b0, w_limit})) begin
                                n_res_st = ffha_pkg::ST_NOSPACE;
                            end else begin
                                w_we       = 1'b1;
                                w_wa       = r_count[IW-1:0];
                                w_wd.free  = 1'b0;
                                w_wd.size  = r_sz[15:0];
                                n_count    = r_count + 1'b1;
                                n_res_addr = 16'(r_top + HDR17);
                                n_res_st   = ffha_pkg::ST_ALLOC;
                                n_top      = r_top + HDR17 + r_sz;
                            end
                        end
                    end
                end
            end

            ffha_pkg::S_FNEXT: begin
                w_nf   = ((CW'(r_i) + 1'b1) < r_count) && r_rdata.free;
                w_pf   = (r_i != '0) && r_prev.free;
                w_we   = 1'b1;
                n_pend = 1'b0;
                n_d    = 2'd1;
                w_wd.free = 1'b1;
                priority if (w_pf && w_nf) begin
                    w_wa      = r_i - 1'b1;
                    w_wd.size = r_prev.size + HDR16 + r_hit.size + HDR16 + r_rdata.size;
                    n_d       = 2'd2;
                    n_ra      = RW'(r_i) + RW'(2);
                    n_state   = ffha_pkg::S_SHDN;
                end else if (w_pf) begin
                    w_wa      = r_i - 1'b1;
                    w_wd.size = r_prev.size + HDR16 + r_hit.size;
                    n_ra      = RW'(r_i) + RW'(1);
                    n_state   = ffha_pkg::S_SHDN;
                end else if (w_nf) begin
                    w_wa      = r_i;
                    w_wd.size = r_hit.size + HDR16 + r_rdata.size;
                    n_ra      = RW'(r_i) + RW'(2);
                    n_state   = ffha_pkg::S_SHDN;
                end else begin
                    w_wa      = r_i;
                    w_wd.size = r_hit.size;
                    n_state   = ffha_pkg::S_RESP;
                end
            end

            ffha_pkg::S_SHDN: begin
                // close the gap: entry src moves to src - d
                if (r_pend) begin
                    w_we = 1'b1;
                    w_wa = r_cur - IW'(r_d);
                    w_wd = r_rdata;
                end
                if (r_ra < RW'(r_count)) begin
                    w_ra   = r_ra[IW-1:0];
                    n_cur  = r_ra[IW-1:0];
                    n_ra   = r_ra + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - CW'(r_d);
                        n_state = ffha_pkg::S_RESP;
                    end
                end
            end

            ffha_pkg::S_SHUP: begin
                // open a slot: entry src moves to src + 1, top down
                if (r_pend) begin
                    w_we = 1'b1;
                    w_wa = r_cur + 1'b1;
                    w_wd = r_rdata;
                end
                if (r_ra > (RW'(r_i) + RW'(1))) begin
                    w_ra   = IW'(r_ra - 1'b1);
                    n_cur  = IW'(r_ra - 1'b1);
                    n_ra   = r_ra - 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        w_we      = 1'b1;
                        w_wa      = r_i + 1'b1;
                        w_wd.free = 1'b1;
                        w_wd.size = r_rem;
                        n_count   = r_count + 1'b1;
                        n_state   = ffha_pkg::S_RESP;
                    end
                end
            end

            ffha_pkg::S_RESP: begin
                if (!r_ovalid || w_out_acc) begin
                    n_ovalid = 1'b1;
                    n_oaddr  = r_res_addr;
                    n_ost    = r_res_st;
                    n_state  = ffha_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ffha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
